FILE: hdl/dwg_pkg.sv
// Shared types, widths and constants of the wave table sample generator.
// Holds the sine ROM contents, built at elaboration from a fixed-point series.
// No dependencies.
`default_nettype none
package dwg_pkg;

	// Sizing
	localparam int MAX_TABLE_SIZE = 2048;
	localparam int SINE_ROM_DEPTH = 1024;

	// Field widths
	localparam int IDX_W     = 11;
	localparam int CODE_W    = 12;
	localparam int RELOAD_W  = 16;
	localparam int AMP_W     = 12;
	localparam int FREQ_W    = 11;
	localparam int TSIZE_W   = 12;
	localparam int SHAPE_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 12;

	// Datapath widths
	localparam int FRAC_W  = 16;
	localparam int K_W     = $clog2(SINE_ROM_DEPTH);
	localparam int Q_W     = 28;
	localparam int NUM_W   = IDX_W + Q_W;
	localparam int SCALE_W = 28;
	localparam int SIZE_W  = $clog2(MAX_TABLE_SIZE + 1);
	localparam int REM_W   = (SIZE_W > IDX_W) ? SIZE_W : IDX_W;
	localparam int DIV_BPS = 4;
	localparam int DIV_ST  = Q_W / DIV_BPS;
	localparam int ND_W    = 40;
	localparam int DD_W    = FREQ_W + SIZE_W;
	localparam int DREM_W  = DD_W + 1;
	localparam int CNT_W   = $clog2(ND_W);

	// Constants
	localparam int unsigned MIDSCALE  = 2048;
	localparam int unsigned CODE_MAX  = 4095;
	localparam int unsigned AMP_DIV   = 3300;
	localparam int unsigned CLOCK_HZ  = 84000000;
	localparam int unsigned FREQ_ZERO = 100;
	localparam int unsigned RELOAD_MAX = 65535;

	// Amplitude scale: amp * (CODE_MAX << FRAC_W) / AMP_DIV split into an integer
	// step per millivolt and a reduced fraction, the fraction floored by a
	// reciprocal multiply that is exact for every 12-bit amplitude
	localparam int unsigned AMP_STEP     = (CODE_MAX << FRAC_W) / AMP_DIV;
	localparam int unsigned AMP_GCD      = 60;
	localparam int unsigned AMP_FRAC_NUM = ((CODE_MAX << FRAC_W) % AMP_DIV) / AMP_GCD;
	localparam int unsigned AMP_FRAC_DEN = AMP_DIV / AMP_GCD;
	localparam int unsigned RECIP_SH     = 22;
	localparam int unsigned RECIP_M      = ((1 << RECIP_SH) + AMP_FRAC_DEN - 1) / AMP_FRAC_DEN;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd3;

	// Wave shapes
	localparam logic [SHAPE_W-1:0] SHAPE_SINE   = 2'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 2'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_TRI    = 2'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_OFF    = 2'd3;

	// Derived-value sequencer states
	typedef enum logic [2:0] {
		CS_LOAD_SCALE,
		CS_LOAD_PER,
		CS_DIV_PER,
		CS_FINISH,
		CS_IDLE
	} cfg_state_t;

	// Per-item flags that ride along the pipeline
	typedef struct packed {
		logic [SHAPE_W-1:0] shape;
		logic               in_range;
		logic               up;
	} meta_t;

	typedef logic signed [31:0] sine_rom_t [0:SINE_ROM_DEPTH];

	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// sin(a) on the first quadrant, a and result in Q2.30
	function automatic longint unsigned quarter_sine(input longint unsigned a);
		longint unsigned x2;
		longint unsigned t;
		x2 = (a * a) >> 30;
		t = ONE_Q30 - x2 / 110;
		t = ONE_Q30 - ((x2 * t) >> 30) / 72;
		t = ONE_Q30 - ((x2 * t) >> 30) / 42;
		t = ONE_Q30 - ((x2 * t) >> 30) / 20;
		t = ONE_Q30 - ((x2 * t) >> 30) / 6;
		return (a * t) >> 30;
	endfunction

	// One full period, last entry repeats the first for interpolation
	function automatic sine_rom_t gen_sine_rom();
		sine_rom_t rom;
		longint unsigned q;
		longint unsigned quad;
		longint unsigned r;
		longint unsigned s;
		for (int k = 0; k <= SINE_ROM_DEPTH; k++) begin
			q = 4 * longint'(k);
			quad = (q / SINE_ROM_DEPTH) & 3;
			r = q % SINE_ROM_DEPTH;
			if (quad[0]) begin
				r = SINE_ROM_DEPTH - r;
			end
			s = quarter_sine(HALF_PI_Q30 * r / SINE_ROM_DEPTH);
			rom[k] = quad[1] ? -32'(s) : 32'(s);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = gen_sine_rom();

endpackage
`default_nettype wire

FILE: hdl/dac_wave_table_sample_gen_top.sv
// Wave table sample generator: sample index in, DAC code and timer reload out.
// Depends on dwg_pkg (widths, constants, sine ROM contents).
`default_nettype none
// Takes one item per clock and returns one result per item. The stages are
// one input stage, seven stages of a radix-2 divider that retire four
// quotient bits each, a sine ROM read, an interpolation multiply, an
// amplitude multiply and the output register. After reset and after each
// configuration write the block recomputes the amplitude scale with a
// reciprocal multiply and the timer reload with a bit-serial divider;
// s_axis_tready is low while it does so. Result items are taken
// by m_axis_tready; the whole pipeline holds while a finished item waits.
module dac_wave_table_sample_gen_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [dwg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dwg_pkg::CFG_W-1:0]     cfg_data,
	// Input items
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [15:0]                   s_axis_tdata,  // [10:0] sample_index
	// Result items
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [31:0]                        m_axis_tdata   // [11:0] dac_code,
	                                                          // [27:12] timer_reload,
	                                                          // [28] index_valid
);
	import dwg_pkg::*;

	// Configuration registers
	logic [SHAPE_W-1:0] shape_q;
	logic [AMP_W-1:0]   amp_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [TSIZE_W-1:0] tsize_q;

	// Derived values
	logic [SCALE_W-1:0]  scale_q;
	logic [RELOAD_W-1:0] reload_q;

	// Derived-value sequencer
	cfg_state_t        state_q, state_nxt;
	logic [ND_W-1:0]   nd_q;
	logic [DD_W-1:0]   dd_q;
	logic [DREM_W-1:0] drem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy, ld_scale, ld_per, div_step, store_reload;

	logic [SIZE_W-1:0] size_eff;
	logic [SIZE_W-1:0] hs_eff;
	logic [FREQ_W-1:0] freq_eff;

	// Clamp the size and frequency registers
	always_comb begin
		if (tsize_q == '0) begin
			size_eff = SIZE_W'(1);
		end else if (32'(tsize_q) > MAX_TABLE_SIZE) begin
			size_eff = SIZE_W'(MAX_TABLE_SIZE);
		end else begin
			size_eff = SIZE_W'(tsize_q);
		end
		hs_eff = (size_eff >> 1 == '0) ? SIZE_W'(1) : (size_eff >> 1);
		freq_eff = (freq_q == '0) ? FREQ_W'(FREQ_ZERO) : freq_q;
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= SHAPE_SINE;
			amp_q   <= AMP_W'(1000);
			freq_q  <= FREQ_W'(1000);
			tsize_q <= TSIZE_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHAPE: shape_q <= cfg_data[SHAPE_W-1:0];
				REG_AMP:   amp_q   <= cfg_data[AMP_W-1:0];
				REG_FREQ:  freq_q  <= cfg_data[FREQ_W-1:0];
				REG_SIZE:  tsize_q <= cfg_data[TSIZE_W-1:0];
				default:   ;
			endcase
		end
	end

	// Sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CS_LOAD_SCALE: state_nxt = CS_LOAD_PER;
			CS_LOAD_PER:   state_nxt = CS_DIV_PER;
			CS_DIV_PER:    if (cnt_q == CNT_W'(ND_W - 1)) state_nxt = CS_FINISH;
			CS_FINISH:     state_nxt = CS_IDLE;
			CS_IDLE:       state_nxt = CS_IDLE;
			default:       state_nxt = CS_IDLE;
		endcase
		if (cfg_we) begin
			state_nxt = CS_LOAD_SCALE;
		end
	end

	// Sequencer outputs
	always_comb begin
		busy         = (state_q != CS_IDLE);
		ld_scale     = (state_q == CS_LOAD_SCALE);
		ld_per       = (state_q == CS_LOAD_PER);
		div_step     = (state_q == CS_DIV_PER);
		store_reload = (state_q == CS_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_LOAD_SCALE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Amplitude scale: integer step per millivolt plus the floored fraction, clamped
	logic [15:0]        afrac_n;
	logic [32:0]        afrac_p;
	logic [29:0]        scale_raw;
	logic [SCALE_W-1:0] scale_c;
	always_comb begin
		afrac_n   = 16'(amp_q) * 16'(AMP_FRAC_NUM);
		afrac_p   = 33'(afrac_n) * 33'(RECIP_M);
		scale_raw = 30'(amp_q) * 30'(AMP_STEP) + 30'(afrac_p >> RECIP_SH);
		scale_c   = (scale_raw > 30'(CODE_MAX << FRAC_W)) ?
			SCALE_W'(CODE_MAX << FRAC_W) : SCALE_W'(scale_raw);
	end

	// Bit-serial divider step
	logic [DREM_W:0]   dt;
	logic              dge;
	logic [DREM_W-1:0] drem_nxt;
	always_comb begin
		dt = {drem_q, nd_q[ND_W-1]};
		dge = (dt >= (DREM_W+1)'(dd_q));
		drem_nxt = dge ? DREM_W'(dt - (DREM_W+1)'(dd_q)) : DREM_W'(dt);
	end

	// Clamp the quotient into a reload value
	logic [RELOAD_W-1:0] reload_c;
	always_comb begin
		if (nd_q < ND_W'(2)) begin
			reload_c = RELOAD_W'(1);
		end else if (nd_q > ND_W'(RELOAD_MAX)) begin
			reload_c = RELOAD_W'(RELOAD_MAX - 1);
		end else begin
			reload_c = RELOAD_W'(nd_q - ND_W'(1));
		end
	end

	// Sequencer datapath: load operands, iterate, store results
	always_ff @(posedge clk) begin
		if (ld_per) begin
			nd_q   <= ND_W'(CLOCK_HZ);
			dd_q   <= DD_W'(freq_eff) * DD_W'(size_eff);
			drem_q <= '0;
			cnt_q  <= '0;
		end else if (div_step) begin
			nd_q   <= {nd_q[ND_W-2:0], dge};
			drem_q <= drem_nxt;
			cnt_q  <= cnt_q + CNT_W'(1);
		end
	end

	// Hold the scale and the reload
	always_ff @(posedge clk) begin
		if (ld_scale) begin
			scale_q <= scale_c;
		end
		if (store_reload) begin
			reload_q <= reload_c;
		end
	end

	logic [SCALE_W-2:0] half;
	assign half = scale_q[SCALE_W-1:1];

	// Pipeline advance
	logic en, accept;
	logic out_vld_q;
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en && !busy;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Stage 1: range check, numerator and divisor
	logic [IDX_W-1:0] idx;
	logic             tri_up;
	logic [IDX_W-1:0] tri_i;
	meta_t            meta_c;
	assign idx = s_axis_tdata[IDX_W-1:0];
	always_comb begin
		tri_up = (SIZE_W'(idx) < hs_eff);
		tri_i  = tri_up ? idx : IDX_W'(idx - IDX_W'(hs_eff));
		meta_c.shape    = shape_q;
		meta_c.in_range = (SIZE_W'(idx) < size_eff);
		meta_c.up       = (shape_q == SHAPE_SQUARE) ?
			(SIZE_W'(idx) < (size_eff >> 1)) : tri_up;
	end

	logic              v_s1;
	logic [NUM_W-1:0]  num_s1;
	logic [SIZE_W-1:0] den_s1;
	meta_t             meta_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (shape_q == SHAPE_TRI) begin
				num_s1 <= NUM_W'(scale_q) * NUM_W'(tri_i);
				den_s1 <= hs_eff;
			end else begin
				num_s1 <= NUM_W'(idx) << (K_W + FRAC_W);
				den_s1 <= size_eff;
			end
			meta_s1 <= meta_c;
		end
	end

	// Divider stages, four quotient bits each
	logic              div_v_s    [1:DIV_ST];
	logic [Q_W-1:0]    div_nq_s   [1:DIV_ST];
	logic [REM_W-1:0]  div_rem_s  [1:DIV_ST];
	logic [SIZE_W-1:0] div_den_s  [1:DIV_ST];
	meta_t             div_meta_s [1:DIV_ST];

	for (genvar gi = 0; gi < DIV_ST; gi++) begin : g_div
		logic              src_v;
		logic [Q_W-1:0]    src_nq;
		logic [REM_W-1:0]  src_rem;
		logic [SIZE_W-1:0] src_den;
		meta_t             src_meta;
		logic [Q_W-1:0]    nq_c;
		logic [REM_W-1:0]  rem_c;

		if (gi == 0) begin : g_first
			assign src_v    = v_s1;
			assign src_nq   = num_s1[Q_W-1:0];
			assign src_rem  = REM_W'(num_s1[NUM_W-1:Q_W]);
			assign src_den  = den_s1;
			assign src_meta = meta_s1;
		end else begin : g_next
			assign src_v    = div_v_s[gi];
			assign src_nq   = div_nq_s[gi];
			assign src_rem  = div_rem_s[gi];
			assign src_den  = div_den_s[gi];
			assign src_meta = div_meta_s[gi];
		end

		// Retire four quotient bits
		always_comb begin
			logic [REM_W:0] t;
			logic           ge;
			nq_c  = src_nq;
			rem_c = src_rem;
			for (int j = 0; j < DIV_BPS; j++) begin
				t  = {rem_c, nq_c[Q_W-1]};
				ge = (t >= (REM_W+1)'(src_den));
				if (ge) begin
					t = t - (REM_W+1)'(src_den);
				end
				rem_c = t[REM_W-1:0];
				nq_c  = {nq_c[Q_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[gi+1] <= 1'b0;
			end else if (en) begin
				div_v_s[gi+1] <= src_v;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_nq_s[gi+1]   <= nq_c;
				div_rem_s[gi+1]  <= rem_c;
				div_den_s[gi+1]  <= src_den;
				div_meta_s[gi+1] <= src_meta;
			end
		end
	end

	// Stage A: read both sine neighbors
	logic [Q_W-1:0] q_d;
	logic [K_W:0]   k_d;
	assign q_d = div_nq_s[DIV_ST];
	assign k_d = {1'b0, q_d[K_W+FRAC_W-1:FRAC_W]};

	logic               v_sa;
	logic signed [31:0] rom0_sa, rom1_sa;
	logic [FRAC_W-1:0]  frac_sa;
	logic [Q_W-1:0]     q_sa;
	meta_t              meta_sa;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
		end else if (en) begin
			v_sa <= div_v_s[DIV_ST];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rom0_sa <= SINE_ROM[k_d];
			rom1_sa <= SINE_ROM[k_d + (K_W+1)'(1)];
			frac_sa <= q_d[FRAC_W-1:0];
			q_sa    <= q_d;
			meta_sa <= div_meta_s[DIV_ST];
		end
	end

	// Stage B: interpolate, truncating toward zero; triangle level
	logic signed [32:0] diff;
	logic signed [49:0] iprod, iadj;
	logic signed [31:0] s_c;
	logic signed [30:0] tri_v;
	always_comb begin
		diff  = rom1_sa - rom0_sa;
		iprod = diff * $signed({1'b0, frac_sa});
		iadj  = (iprod < 0) ? iprod + 50'sd65535 : iprod;
		iadj  = iadj >>> FRAC_W;
		s_c   = rom0_sa + iadj[31:0];
		if (meta_sa.up) begin
			tri_v = $signed(31'(MIDSCALE << FRAC_W)) - $signed({4'b0, half})
				+ $signed({3'b0, q_sa});
		end else begin
			tri_v = $signed(31'(MIDSCALE << FRAC_W)) + $signed({4'b0, half})
				- $signed({3'b0, q_sa});
		end
	end

	logic               v_sb;
	logic signed [31:0] s_sb;
	logic signed [30:0] tri_sb;
	meta_t              meta_sb;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sb <= 1'b0;
		end else if (en) begin
			v_sb <= v_sa;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			s_sb    <= s_c;
			tri_sb  <= tri_v;
			meta_sb <= meta_sa;
		end
	end

	// Stage C: scale the sine and add midscale; finish the triangle code
	logic signed [59:0] aprod;
	logic signed [60:0] tot_c;
	logic [CODE_W-1:0]  tri_code;
	always_comb begin
		aprod = $signed({1'b0, half}) * s_sb;
		tot_c = (61'sd1 <<< 57) + aprod;
		if (tri_sb < 0) begin
			tri_code = '0;
		end else if ((tri_sb >>> FRAC_W) > 31'(CODE_MAX)) begin
			tri_code = CODE_W'(CODE_MAX);
		end else begin
			tri_code = tri_sb[FRAC_W+CODE_W-1:FRAC_W];
		end
	end

	logic               v_sc;
	logic signed [60:0] tot_sc;
	logic [CODE_W-1:0]  tri_sc;
	meta_t              meta_sc;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc <= 1'b0;
		end else if (en) begin
			v_sc <= v_sb;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tot_sc  <= tot_c;
			tri_sc  <= tri_code;
			meta_sc <= meta_sb;
		end
	end

	// Output stage: pick the code for the shape
	logic [CODE_W-1:0] code_c;
	logic [SCALE_W:0]  sq_v;
	always_comb begin
		sq_v = meta_sc.up ? (SCALE_W+1)'(MIDSCALE << FRAC_W) + (SCALE_W+1)'(half)
			: (SCALE_W+1)'(MIDSCALE << FRAC_W) - (SCALE_W+1)'(half);
		code_c = CODE_W'(MIDSCALE);
		if (meta_sc.in_range) begin
			case (meta_sc.shape)
				SHAPE_SINE: begin
					if (tot_sc < 0) begin
						code_c = '0;
					end else if ((tot_sc >>> 46) > 61'sd4095) begin
						code_c = CODE_W'(CODE_MAX);
					end else begin
						code_c = tot_sc[46+CODE_W-1:46];
					end
				end
				SHAPE_SQUARE: begin
					code_c = ((sq_v >> FRAC_W) > (SCALE_W+1)'(CODE_MAX)) ?
						CODE_W'(CODE_MAX) : sq_v[FRAC_W+CODE_W-1:FRAC_W];
				end
				SHAPE_TRI: code_c = tri_sc;
				SHAPE_OFF: code_c = CODE_W'(MIDSCALE);
				default:   code_c = CODE_W'(MIDSCALE);
			endcase
		end
	end

	logic [CODE_W-1:0] code_q;
	logic              iv_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= v_sc;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			code_q <= code_c;
			iv_q   <= meta_sc.in_range;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {3'b0, iv_q, reload_q, code_q};

endmodule
`default_nettype wire
